[rtl/hsfc_pkg.sv]
// ----------------------------------------------------------------------------
// hsfc_pkg
// shared types and constants for the half/single format converter
// ----------------------------------------------------------------------------
`default_nettype none
package hsfc_pkg;

  typedef enum logic {
    OP_H2S = 1'b0,
    OP_S2H = 1'b1
  } op_e;

  localparam logic [4:0]  HalfExpMax  = 5'h1F;
  localparam logic [15:0] HalfInf     = 16'h7C00;
  localparam logic [9:0]  HalfQnan    = 10'h200;
  localparam logic [7:0]  SglExpMax   = 8'hFF;
  localparam logic [7:0]  SglZeroLim  = 8'd102;
  localparam logic [7:0]  SglInfLim   = 8'd143;
  localparam logic [7:0]  SglSubLim   = 8'd112;
  localparam logic [31:0] SglInf      = 32'h7F80_0000;

  typedef enum logic [2:0] {
    CL_ZERO,
    CL_INF,
    CL_NAN,
    CL_SUB,
    CL_NORM
  } cls_e;

  typedef struct packed {
    op_e         op;
    cls_e        cls;
    logic        sgn;
    logic [7:0]  exp;
    logic [22:0] frac;
    logic [3:0]  lz;
    logic [4:0]  sh;
  } st_t;

endpackage
`default_nettype wire

[rtl/half_single_format_convert.sv]
// ----------------------------------------------------------------------------
// half_single_format_convert
// converts half to single or single to half (truncating), when not stalled one transfer a clock
// ----------------------------------------------------------------------------
// an input transfer is registered in s1_q, s2_q and r_q, in that order, before its result transfer
// throughput: one transfer per cycle unless a pending result is stalled, set by the three-stage pipeline
// stall_i freezes all stages while a result is pending; stall_o then follows stall_i
// reset clears the valid bits of all stages; payload is not reset
`default_nettype none
module half_single_format_convert (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  output logic             stall_o,
  input  wire logic        opcode_i,
  input  wire logic [31:0] operand_i,
  output logic             valid_o,
  input  wire logic        stall_i,
  output logic [31:0]      result_o
);

  logic v1_q, v2_q, v3_q;
  logic adv;
  hsfc_pkg::st_t s1_d, s1_q, s2_d, s2_q;
  logic [31:0] r_d, r_q;

  assign adv     = !(v3_q && stall_i);
  assign stall_o = !adv;
  assign valid_o = v3_q;
  assign result_o = r_q;

  // stage 1: unpack and classify
  always_comb begin
    s1_d = '0;
    s1_d.op = hsfc_pkg::op_e'(opcode_i);
    if (opcode_i == hsfc_pkg::OP_H2S) begin
      s1_d.sgn  = operand_i[15];
      s1_d.exp  = {3'b0, operand_i[14:10]};
      s1_d.frac = {operand_i[9:0], 13'b0};
      if (operand_i[14:10] == hsfc_pkg::HalfExpMax)
        s1_d.cls = (operand_i[9:0] == '0) ? hsfc_pkg::CL_INF : hsfc_pkg::CL_NAN;
      else if (operand_i[14:10] == '0)
        s1_d.cls = (operand_i[9:0] == '0) ? hsfc_pkg::CL_ZERO : hsfc_pkg::CL_SUB;
      else
        s1_d.cls = hsfc_pkg::CL_NORM;
    end else begin
      s1_d.sgn  = operand_i[31];
      s1_d.exp  = operand_i[30:23];
      s1_d.frac = operand_i[22:0];
      if (operand_i[30:23] == hsfc_pkg::SglExpMax)
        s1_d.cls = (operand_i[22:0] == '0) ? hsfc_pkg::CL_INF : hsfc_pkg::CL_NAN;
      else if (operand_i[30:23] <= hsfc_pkg::SglZeroLim)
        s1_d.cls = hsfc_pkg::CL_ZERO;
      else if (operand_i[30:23] >= hsfc_pkg::SglInfLim)
        s1_d.cls = hsfc_pkg::CL_INF;
      else if (operand_i[30:23] <= hsfc_pkg::SglSubLim)
        s1_d.cls = hsfc_pkg::CL_SUB;
      else
        s1_d.cls = hsfc_pkg::CL_NORM;
    end
  end

  // stage 2: leading-zero count and shift amount
  always_comb begin
    s2_d = s1_q;
    s2_d.lz = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (s1_q.frac[13 + i]) s2_d.lz = 4'(9 - i);
    end
    s2_d.sh = 5'(8'd126 - s1_q.exp);
  end

  // stage 3: pack
  logic [23:0] mant;
  logic [22:0] hsub;
  logic [9:0]  nfrac;
  always_comb begin
    mant  = {1'b1, s2_q.frac} >> s2_q.sh;
    hsub  = s2_q.frac << (s2_q.lz + 4'd1);
    nfrac = (s2_q.frac[22:13] != '0) ? s2_q.frac[22:13] : hsfc_pkg::HalfQnan;
    r_d = '0;
    if (s2_q.op == hsfc_pkg::OP_H2S) begin
      case (s2_q.cls)
        hsfc_pkg::CL_INF:  r_d = {s2_q.sgn, 31'b0} | hsfc_pkg::SglInf;
        hsfc_pkg::CL_NAN:  r_d = {s2_q.sgn, 31'b0} | hsfc_pkg::SglInf | {9'b0, s2_q.frac};
        hsfc_pkg::CL_SUB:  r_d = {s2_q.sgn, 8'(8'd112 - {4'b0, s2_q.lz}), hsub};
        hsfc_pkg::CL_NORM: r_d = {s2_q.sgn, 8'(s2_q.exp + 8'd112), s2_q.frac};
        default:           r_d = {s2_q.sgn, 31'b0};
      endcase
    end else begin
      case (s2_q.cls)
        hsfc_pkg::CL_INF:  r_d = {16'b0, {s2_q.sgn, 15'b0} | hsfc_pkg::HalfInf};
        hsfc_pkg::CL_NAN:  r_d = {16'b0, {s2_q.sgn, 15'b0} | hsfc_pkg::HalfInf | {6'b0, nfrac}};
        hsfc_pkg::CL_SUB:  r_d = {16'b0, s2_q.sgn, 5'b0, mant[9:0]};
        hsfc_pkg::CL_NORM: r_d = {16'b0, s2_q.sgn, 5'(s2_q.exp - 8'd112), s2_q.frac[22:13]};
        default:           r_d = {16'b0, s2_q.sgn, 15'b0};
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q <= s1_d;
      s2_q <= s2_d;
      r_q  <= r_d;
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && stall_i |=> v3_q && $stable(r_q))
    else $error("result changed under stall");
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> v3_q)
    else $error("stall without pending result");
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !stall_o && v2_q |=> v3_q)
    else $error("valid lost between stages");
  a_half: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && $past(adv) && $past(s2_q.op) == hsfc_pkg::OP_S2H |-> r_q[31:16] == '0)
    else $error("half result upper bits set");

endmodule
`default_nettype wire
